// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds the screen geometry, character codes, request codes and controller states.
// No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  typedef enum logic [1:0] {
    REQ_PUT_CURSOR = 2'd0,
    REQ_PUT_POS    = 2'd1,
    REQ_READ       = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_FIN
  } state_t;

  function automatic logic [CELL_AW-1:0] cell_index(input logic [4:0] r, input logic [6:0] c);
    logic [CELL_AW-1:0] idx;
    idx = CELL_AW'(CELL_AW'(r) * CELL_AW'(SCREEN_COLS) + CELL_AW'(c));
    return idx;
  endfunction

endpackage

// ===== hdl/text_console_writer_core.sv =====
// Text console writer: screen memory, cursor and request controller.
// Depends on tcw_pkg for geometry, codes and states.
//
// Usage: requests enter on in_valid/in_ready with req_type, char_code, col and row;
// each request gives exactly one result on out_valid/out_ready. The user must
// write the attribute register with cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this. The screen lives in one
// single-port-write, single-port-read memory of SCREEN_COLS*SCREEN_ROWS cells
// with a registered read. A put, read or ignored request passes through EXEC,
// then FIN, where the result is loaded and out_valid raised; only then does the
// block return to IDLE for the next item, so a new request waits for the last.
// A put that runs past the bottom scrolls the screen with a read-modify-write
// sweep over every cell; a clear screen request writes every cell. One request
// is handled at a time. After reset the block clears the memory to zero and
// holds in_ready low until that pass is done; the attribute resets to 7.
// The result sits in an output register; while the receiver stalls, the block
// finishes the current request and then waits before taking the next one.
module text_console_writer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic [6:0] col,
  input  logic [4:0] row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic       scrolled,
  output logic       bad_position,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int AW = tcw_pkg::CELL_AW;
  localparam int SW = tcw_pkg::SWEEP_W;

  logic [15:0] mem [tcw_pkg::CELL_COUNT];
  logic [15:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  tcw_pkg::state_t    state;
  tcw_pkg::state_t    state_next;
  tcw_pkg::req_type_t req_q;
  logic [7:0] char_q;
  logic [6:0] col_q;
  logic [4:0] row_q;
  logic [7:0] attribute;
  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic       res_scrolled;
  logic       res_bad;
  logic       res_read;
  logic [SW-1:0] sweep_idx;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          pend_bottom;

  logic          on_screen;
  logic          is_put;
  logic          newline;
  logic [6:0]    base_col;
  logic [4:0]    base_row;
  logic [AW-1:0] target;
  logic          wrap;
  logic [5:0]    row_inc;
  logic [5:0]    adv_row;
  logic [6:0]    adv_col;
  logic          do_scroll;
  logic          out_free;
  logic          sweep_end;

  always_comb begin
    on_screen = ({1'b0, col_q} < 8'(tcw_pkg::SCREEN_COLS)) &&
                ({1'b0, row_q} < 6'(tcw_pkg::SCREEN_ROWS));
    is_put    = (req_q == tcw_pkg::REQ_PUT_CURSOR) ||
                ((req_q == tcw_pkg::REQ_PUT_POS) && on_screen);
    newline   = (char_q == tcw_pkg::CHAR_NEWLINE);
    base_col  = (req_q == tcw_pkg::REQ_PUT_CURSOR) ? cur_col : col_q;
    base_row  = (req_q == tcw_pkg::REQ_PUT_CURSOR) ? cur_row : row_q;
    target    = tcw_pkg::cell_index(base_row, base_col);
    wrap      = newline || (base_col == 7'(tcw_pkg::SCREEN_COLS - 1));
    row_inc   = {1'b0, base_row} + 6'd1;
    adv_row   = wrap ? row_inc : {1'b0, base_row};
    adv_col   = wrap ? 7'd0 : base_col + 7'd1;
    do_scroll = is_put && (adv_row == 6'(tcw_pkg::SCREEN_ROWS));
    out_free  = !out_valid || out_ready;
    sweep_end = (sweep_idx == SW'(tcw_pkg::CELL_COUNT - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sweep_end) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        if (req_q == tcw_pkg::REQ_CLEAR) state_next = tcw_pkg::ST_CLEAR;
        else if (do_scroll) state_next = tcw_pkg::ST_SCROLL;
        else state_next = tcw_pkg::ST_FIN;
      end
      tcw_pkg::ST_SCROLL: begin
        if ((sweep_idx == SW'(tcw_pkg::CELL_COUNT)) && !pend) state_next = tcw_pkg::ST_FIN;
      end
      tcw_pkg::ST_CLEAR: begin
        if (sweep_end) state_next = tcw_pkg::ST_FIN;
      end
      tcw_pkg::ST_FIN: begin
        if (out_free) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = target;
    mem_wdata = {attribute, char_q};
    mem_re    = 1'b0;
    mem_raddr = target;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx[AW-1:0];
        mem_wdata = 16'd0;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      tcw_pkg::ST_EXEC: begin
        mem_we = is_put && !newline;
        mem_re = (req_q == tcw_pkg::REQ_READ) && on_screen;
      end
      tcw_pkg::ST_SCROLL: begin
        mem_re = (sweep_idx < SW'(tcw_pkg::CELL_COUNT));
        if (sweep_idx < SW'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS)) begin
          mem_raddr = AW'(sweep_idx + SW'(tcw_pkg::SCREEN_COLS));
        end else begin
          mem_raddr = sweep_idx[AW-1:0];
        end
        mem_we    = pend;
        mem_waddr = pend_idx;
        mem_wdata = pend_bottom ? {rd_data[15:8], tcw_pkg::CHAR_SPACE} : rd_data;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx[AW-1:0];
        mem_wdata = {attribute, tcw_pkg::CHAR_SPACE};
      end
      tcw_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      sweep_idx <= '0;
      pend      <= 1'b0;
      attribute <= tcw_pkg::ATTR_RESET;
      cur_col   <= 7'd0;
      cur_row   <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) attribute <= cfg_wr_data;

      if (state != state_next) begin
        sweep_idx <= '0;
      end else if (((state == tcw_pkg::ST_INIT) || (state == tcw_pkg::ST_CLEAR) ||
                    (state == tcw_pkg::ST_SCROLL)) &&
                   (sweep_idx != SW'(tcw_pkg::CELL_COUNT))) begin
        sweep_idx <= sweep_idx + SW'(1);
      end

      pend <= (state == tcw_pkg::ST_SCROLL) && (sweep_idx < SW'(tcw_pkg::CELL_COUNT));

      if (state == tcw_pkg::ST_EXEC) begin
        if (req_q == tcw_pkg::REQ_CLEAR) begin
          cur_col <= 7'd0;
          cur_row <= 5'd0;
        end else if (do_scroll) begin
          cur_col <= 7'd0;
          cur_row <= 5'(tcw_pkg::SCREEN_ROWS - 1);
        end else if (is_put) begin
          cur_col <= adv_col;
          cur_row <= adv_row[4:0];
        end
      end

      if ((state == tcw_pkg::ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q  <= tcw_pkg::req_type_t'(req_type);
      char_q <= char_code;
      col_q  <= col;
      row_q  <= row;
    end

    pend_idx    <= sweep_idx[AW-1:0];
    pend_bottom <= (sweep_idx >= SW'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS));

    if (state == tcw_pkg::ST_EXEC) begin
      res_scrolled <= do_scroll;
      res_bad      <= ((req_q == tcw_pkg::REQ_PUT_POS) || (req_q == tcw_pkg::REQ_READ)) &&
                      !on_screen;
      res_read     <= (req_q == tcw_pkg::REQ_READ) && on_screen;
    end

    if ((state == tcw_pkg::ST_FIN) && out_free) begin
      cell_char    <= res_read ? rd_data[7:0] : 8'd0;
      cell_attr    <= res_read ? rd_data[15:8] : 8'd0;
      cursor_col   <= cur_col;
      cursor_row   <= cur_row;
      scrolled     <= res_scrolled;
      bad_position <= res_bad;
    end
  end

endmodule
